>>> rtl/deadline_heap_timer_queue_core_macros.svh
// Assertion helpers for the timer queue core.
`ifndef DEADLINE_HEAP_TIMER_QUEUE_CORE_MACROS_SVH
`define DEADLINE_HEAP_TIMER_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DHTQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DHTQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dhtq_pkg.sv
package dhtq_pkg;

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_SAMPLE   = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [15:0] job_tag;
    logic [15:0] delay;
    logic [31:0] now_time;
  } req_item_t;

  typedef struct packed {
    logic        fired;
    logic [15:0] fired_tag;
    logic        status;
    logic [4:0]  pending_count;
  } rsp_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CMP,
    S_UP_PUT,
    S_ROOT,
    S_LAST,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_FINISH
  } state_t;

endpackage

>>> rtl/deadline_heap_timer_queue_core.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_item_t (operation, tag, delay, now)
// rsp       out        rsp_valid/rsp_stall  rsp_item_t (fired, tag, status, count)
//
// One transaction at a time; the heap RAM takes one read and one write per cycle.
// A rejected schedule, a schedule into an empty queue or a sample of an empty queue goes
// straight to the response; any other schedule climbs toward the root, and a sample reads
// the root, then, when it fires, moves the last entry into the root hole and sifts it down
// toward a leaf.
// Reset (rst, synchronous) empties the queue; heap contents are not cleared.
// A new request is taken while a finished response is still stalled.
`include "deadline_heap_timer_queue_core_macros.svh"

module deadline_heap_timer_queue_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  dhtq_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output dhtq_pkg::rsp_item_t rsp
);

  import dhtq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = TIME_BITS + TAG_BITS;

  function automatic logic earlier(input logic [TIME_BITS-1:0] a,
                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return d[TIME_BITS-1];
  endfunction

  state_t state, state_next;

  logic [CW-1:0]        count;
  logic [AW-1:0]        idx;
  logic [EW-1:0]        mov;
  logic [EW-1:0]        lent;
  logic                 has_right;
  logic [TIME_BITS-1:0] now_r;
  logic                 fired_r;
  logic [15:0]          ftag_r;
  logic                 status_r;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [EW-1:0]        ram_wdata, ram_rdata;

  dhtq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_heap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic                 accept, is_sched, is_sample, full, cnt_zero, cnt_one;
  logic [TIME_BITS-1:0] deadline_in;
  logic [EW-1:0]        entry_in;
  logic [CW-1:0]        cnt_m1;
  logic [AW-1:0]        cnt_par, idx_m1, idx_par, gpar;
  logic [CW:0]          lchild, rchild;
  logic                 l_ok, r_ok;
  logic [TIME_BITS-1:0] rd_dl, mov_dl, lent_dl, child_dl;
  logic                 up_swap, due, take_right, dn_swap, rsp_load;
  logic [EW-1:0]        child;
  logic [AW-1:0]        cidx;

  assign accept      = req_valid && !req_stall;
  assign is_sched    = req.operation == OP_SCHEDULE;
  assign is_sample   = req.operation == OP_SAMPLE;
  assign full        = count >= CW'(QUEUE_DEPTH);
  assign cnt_zero    = count == '0;
  assign cnt_one     = count == CW'(1);
  assign deadline_in = TIME_BITS'(req.now_time) + TIME_BITS'(req.delay);
  assign entry_in    = {deadline_in, TAG_BITS'(req.job_tag)};

  assign cnt_m1  = count - CW'(1);
  assign cnt_par = AW'(cnt_m1 >> 1);
  assign idx_m1  = idx - AW'(1);
  assign idx_par = idx_m1 >> 1;
  assign gpar    = (idx_par - AW'(1)) >> 1;

  assign lchild = (CW+1)'({idx, 1'b1});
  assign rchild = lchild + (CW+1)'(1);
  assign l_ok   = lchild < {1'b0, count};
  assign r_ok   = rchild < {1'b0, count};

  assign rd_dl   = ram_rdata[EW-1 -: TIME_BITS];
  assign mov_dl  = mov[EW-1 -: TIME_BITS];
  assign lent_dl = lent[EW-1 -: TIME_BITS];

  assign up_swap    = earlier(mov_dl, rd_dl);
  assign due        = !earlier(now_r, rd_dl);
  assign take_right = has_right && earlier(rd_dl, lent_dl);
  assign child      = take_right ? ram_rdata : lent;
  assign cidx       = take_right ? rchild[AW-1:0] : lchild[AW-1:0];
  assign child_dl   = child[EW-1 -: TIME_BITS];
  assign dn_swap    = earlier(child_dl, mov_dl);

  assign rsp_load = (state == S_FINISH) && (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (is_sched) begin
            state_next = (full || cnt_zero) ? S_FINISH : S_UP_CMP;
          end else begin
            state_next = cnt_zero ? S_FINISH : S_ROOT;
          end
        end
      end
      S_UP_CMP: begin
        if (!up_swap) begin
          state_next = S_FINISH;
        end else if (idx_par == '0) begin
          state_next = S_UP_PUT;
        end
      end
      S_UP_PUT: state_next = S_FINISH;
      S_ROOT:   state_next = (due && !cnt_one) ? S_LAST : S_FINISH;
      S_LAST:   state_next = S_DN_L;
      S_DN_L:   state_next = l_ok ? S_DN_R : S_FINISH;
      S_DN_R:   state_next = S_DN_CMP;
      S_DN_CMP: state_next = dn_swap ? S_DN_L : S_FINISH;
      S_FINISH: state_next = rsp_load ? S_IDLE : S_FINISH;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = mov;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (accept && is_sched && !full) begin
          if (cnt_zero) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = entry_in;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = cnt_par;
          end
        end else if (accept && is_sample && !cnt_zero) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (up_swap) begin
          // move the parent down into the hole and climb
          ram_wdata = ram_rdata;
          if (idx_par != '0) begin
            ram_re    = 1'b1;
            ram_raddr = gpar;
          end
        end
      end
      S_UP_PUT: ram_we = 1'b1;
      S_ROOT: begin
        if (due && !cnt_one) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(cnt_m1);
        end
      end
      S_DN_L: begin
        if (l_ok) begin
          ram_re    = 1'b1;
          ram_raddr = lchild[AW-1:0];
        end else begin
          ram_we = 1'b1;
        end
      end
      S_DN_R: begin
        if (r_ok) begin
          ram_re    = 1'b1;
          ram_raddr = rchild[AW-1:0];
        end
      end
      S_DN_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = dn_swap ? child : mov;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (state == S_IDLE && accept && is_sched && !full) begin
        count <= count + CW'(1);
      end else if (state == S_ROOT && due) begin
        count <= cnt_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          status_r <= (is_sched && full) ? STATUS_FULL : STATUS_OK;
          fired_r  <= 1'b0;
          ftag_r   <= '0;
          now_r    <= TIME_BITS'(req.now_time);
          mov      <= entry_in;
          idx      <= AW'(count);
        end
      end
      S_UP_CMP: begin
        if (up_swap) begin
          idx <= idx_par;
        end
      end
      S_ROOT: begin
        if (due) begin
          fired_r <= 1'b1;
          ftag_r  <= 16'(ram_rdata[TAG_BITS-1:0]);
        end
      end
      S_LAST: begin
        // last entry fills the root hole
        mov <= ram_rdata;
        idx <= '0;
      end
      S_DN_R: begin
        lent      <= ram_rdata;
        has_right <= r_ok;
      end
      S_DN_CMP: begin
        if (dn_swap) begin
          idx <= cidx;
        end
      end
      S_FINISH: begin
        if (rsp_load) begin
          rsp.fired         <= fired_r;
          rsp.fired_tag     <= ftag_r;
          rsp.status        <= status_r;
          rsp.pending_count <= 5'(count);
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  `DHTQ_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(QUEUE_DEPTH), "count beyond depth")
  `DHTQ_ASSERT_IMP(a_ram_collide, clk, rst, ram_we && ram_re, ram_waddr != ram_raddr, "RAM read and write collide")
  `DHTQ_ASSERT_IMP(a_full_count, clk, rst, rsp_valid && rsp.status == STATUS_FULL, rsp.pending_count == 5'(QUEUE_DEPTH) && !rsp.fired, "reject with queue not full")
  `DHTQ_ASSERT_IMP(a_quiet_tag, clk, rst, rsp_valid && !rsp.fired, rsp.fired_tag == 16'd0, "tag without fire")
  `DHTQ_ASSERT_NXT(a_rsp_load, clk, rst, state == S_FINISH && !(rsp_valid && rsp_stall), rsp_valid && state == S_IDLE, "response not loaded")

endmodule

>>> rtl/dhtq_ram.sv
module dhtq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> verif/dhtq_fire_checker.sv
module dhtq_fire_checker
  import dhtq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_stall,
  input  req_item_t req,
  input  logic      rsp_valid,
  input  logic      rsp_stall,
  input  rsp_item_t rsp,
  output int        mismatches,
  output int        waiting,
  output int        fires_seen,
  output int        rejects_seen
);

  localparam int SLOTS = 16;

  logic [31:0] slot_due [SLOTS];
  logic [15:0] slot_tag [SLOTS];
  int          job_count;
  rsp_item_t   heap_answers_q[$];

  initial begin
    mismatches   = 0;
    waiting      = 0;
    fires_seen   = 0;
    rejects_seen = 0;
    job_count    = 0;
  end

  // Wrapping time: a is earlier than b when a - b is negative.
  function automatic logic is_earlier(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff[31];
  endfunction

  function automatic void swap_slots(int i, int j);
    logic [31:0] due;
    logic [15:0] tag;
    due         = slot_due[i];
    tag         = slot_tag[i];
    slot_due[i] = slot_due[j];
    slot_tag[i] = slot_tag[j];
    slot_due[j] = due;
    slot_tag[j] = tag;
  endfunction

  function automatic rsp_item_t heap_apply(req_item_t t);
    rsp_item_t o;
    int        i;
    int        p;
    int        l;
    int        c;
    o = '0;
    o.status = STATUS_OK;
    if (t.operation == OP_SCHEDULE) begin
      if (job_count >= SLOTS) begin
        o.status = STATUS_FULL;
      end else begin
        i = job_count;
        slot_due[i] = t.now_time + 32'(t.delay);
        slot_tag[i] = t.job_tag;
        job_count++;
        // Climb while strictly earlier than the parent; equal deadlines stay put.
        while (i > 0) begin
          p = (i - 1) / 2;
          if (!is_earlier(slot_due[i], slot_due[p])) break;
          swap_slots(i, p);
          i = p;
        end
      end
    end else if (job_count > 0 && !is_earlier(t.now_time, slot_due[0])) begin
      o.fired     = 1'b1;
      o.fired_tag = slot_tag[0];
      job_count--;
      slot_due[0] = slot_due[job_count];
      slot_tag[0] = slot_tag[job_count];
      i = 0;
      l = 1;
      // Sink toward the earlier child, left on a tie.
      while (l < job_count) begin
        c = l;
        if (l + 1 < job_count && is_earlier(slot_due[l + 1], slot_due[l])) c = l + 1;
        if (!is_earlier(slot_due[c], slot_due[i])) break;
        swap_slots(i, c);
        i = c;
        l = 2 * i + 1;
      end
    end
    o.pending_count = 5'(job_count);
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    rsp_item_t want;
    rsp_item_t got;
    if (rst) begin
      job_count = 0;
      heap_answers_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        got = rsp;
        if (heap_answers_q.size() == 0) begin
          report_mismatch($sformatf("response %h with no transaction outstanding", got));
        end else begin
          want = heap_answers_q.pop_front();
          if (got.fired !== want.fired)
            report_mismatch($sformatf("fired got %0d want %0d", got.fired, want.fired));
          if (got.fired_tag !== want.fired_tag)
            report_mismatch($sformatf("fired_tag got %h want %h",
                                      got.fired_tag, want.fired_tag));
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
          if (got.pending_count !== want.pending_count)
            report_mismatch($sformatf("pending_count got %0d want %0d",
                                      got.pending_count, want.pending_count));
        end
      end
      if (req_valid && !req_stall) begin
        want = heap_apply(req);
        if (want.fired) fires_seen++;
        if (want.status == STATUS_FULL) rejects_seen++;
        heap_answers_q = {heap_answers_q, want};
      end
    end
    waiting = heap_answers_q.size();
  end

endmodule

>>> verif/tb.sv
module tb;
  import dhtq_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int ITEMS_PER_PHASE = 430;
  localparam int TAIL_CYCLES     = 40;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  int mismatches;
  int waiting;
  int fires_seen;
  int rejects_seen;

  int          idle_pct    = 0;
  int          stall_pct   = 0;
  int          cycle_count = 0;
  int          sent        = 0;
  logic [31:0] clock_ms    = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  deadline_heap_timer_queue_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  dhtq_fire_checker u_fire_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .mismatches   (mismatches),
    .waiting      (waiting),
    .fires_seen   (fires_seen),
    .rejects_seen (rejects_seen)
  );

  always @(negedge clk) begin
    rsp_stall <= !rst && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses outstanding", cycle_count, waiting);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic req_item_t make_item(logic op, logic [15:0] tag, logic [15:0] dly,
                                          logic [31:0] now);
    req_item_t t;
    t.operation = op;
    t.job_tag   = tag;
    t.delay     = dly;
    t.now_time  = now;
    return t;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(req_item_t item);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every response is back.
  task automatic drain();
    req_valid <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    logic [31:0] base;
    int          k;
    base = 32'hFFFF_FF00;
    send_item(make_item(OP_SAMPLE, 16'h0000, 16'h0000, 32'h0000_0000));
    send_item(make_item(OP_SAMPLE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    // Fill the heap: first deadline wraps past zero, several deadlines tie.
    for (k = 0; k < 16; k++) begin
      send_item(make_item(OP_SCHEDULE,
                          (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'(k * 16'h0F0F),
                          (k == 0) ? 16'hFFFF : 16'((k % 4) * 40),
                          base));
    end
    send_item(make_item(OP_SCHEDULE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(make_item(OP_SAMPLE, 16'h0000, 16'h0000, base - 32'h100));
    repeat (3) send_item(make_item(OP_SAMPLE, 16'h0000, 16'h0000, base + 32'd40));
    repeat (2) send_item(make_item(OP_SAMPLE, 16'h0000, 16'h0000, 32'h0001_0000));
  endtask

  task automatic run_traffic(int count);
    int        n;
    int        sched_pct;
    req_item_t item;
    sched_pct = 50;
    for (n = 0; n < count; n++) begin
      // Swing the schedule/sample mix so the heap fills up and empties again.
      if (n % 40 == 0) sched_pct = $urandom_range(15, 85);
      if (n == count / 2) drain();
      item.job_tag = 16'($urandom);
      if ($urandom_range(0, 99) < 8) begin
        item.operation = OP_SAMPLE;
        item.delay     = 16'($urandom);
        item.now_time  = $urandom;
      end else begin
        item.operation = ($urandom_range(0, 99) < sched_pct) ? OP_SCHEDULE : OP_SAMPLE;
        item.delay     = ($urandom_range(0, 99) < 3) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 600));
        item.now_time  = clock_ms;
      end
      send_item(item);
      // Advance time; an occasional big jump flushes long-delay jobs.
      if ($urandom_range(0, 99) == 0) clock_ms += $urandom_range(0, 65535);
      else clock_ms += $urandom_range(0, 40);
    end
  endtask

  initial begin
    int phase_idle [4];
    int phase_stall[4];
    int p;
    phase_idle  = '{0, 80, 0, 18};
    phase_stall = '{0, 0, 80, 18};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    clock_ms = $urandom;
    run_directed();
    drain();
    for (p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      run_traffic(ITEMS_PER_PHASE);
      drain();
    end
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d transactions across four idle/stall mixes in %0d cycles.",
             sent, cycle_count);
    $display("Heap fired %0d jobs and bounced %0d schedules off a full queue.",
             fires_seen, rejects_seen);
    if (mismatches == 0 && waiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
